// ----- design/xenc_pkg.sv -----
// Package for the x86-64 instruction byte encoder.
// Holds the payload types, the form codes and the byte-buffer helper functions.
`timescale 1ns / 1ps
package xenc_pkg;

  localparam int unsigned MaxBytes = 19;
  localparam int unsigned LenW     = 5;

  typedef enum logic [5:0] {
    CMD_CPU_LD    = 6'd0,  CMD_CPU_ST    = 6'd1,  CMD_MOV_RR    = 6'd2,
    CMD_MOV_I32   = 6'd3,  CMD_MOV_I64   = 6'd4,  CMD_ALU_RSP   = 6'd5,
    CMD_RSP_LD    = 6'd6,  CMD_RSP_ST    = 6'd7,  CMD_ALU_RR    = 6'd8,
    CMD_GRP_F7    = 6'd9,  CMD_BSWAP     = 6'd10, CMD_ADD_I8    = 6'd11,
    CMD_AND_I8    = 6'd12, CMD_SHIFT_CL  = 6'd13, CMD_SHIFT_I   = 6'd14,
    CMD_SETCC     = 6'd15, CMD_MOVSX8    = 6'd16, CMD_MOVSX16   = 6'd17,
    CMD_MOVZX8    = 6'd18, CMD_MOVZX16   = 6'd19, CMD_JCC       = 6'd20,
    CMD_JMP       = 6'd21, CMD_CALL_RAX  = 6'd22, CMD_PROLOGUE  = 6'd23,
    CMD_EPILOGUE  = 6'd24, CMD_MOVD_TOX  = 6'd25, CMD_MOVD_FROMX = 6'd26,
    CMD_SSE_F3    = 6'd27, CMD_UCOMISS   = 6'd28, CMD_CVT_SS2SI = 6'd29,
    CMD_CVT_SI2SS = 6'd30, CMD_STMXCSR   = 6'd31, CMD_LDMXCSR   = 6'd32,
    CMD_MOVZX_IDX = 6'd33, CMD_COUNT     = 6'd34
  } cmd_e;

  typedef enum logic {
    REG_CPU_BASE = 1'b0,
    REG_COUNT    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [5:0]  cmd;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [3:0]  reg_c;
    logic [7:0]  opcode_byte;
    logic [2:0]  sub_op;
    logic [31:0] disp;
    logic [63:0] imm;
    logic        truncate;
    logic [2:0]  saved_count;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  // One request's encoding, byte 0 first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
  } enc_t;

  function automatic enc_t put8(enc_t e, logic [7:0] v);
    enc_t r;
    r = e;
    if (e.len < LenW'(MaxBytes)) begin
      r.bytes[e.len] = v;
      r.len = e.len + LenW'(1);
    end
    return r;
  endfunction

  function automatic enc_t put32(enc_t e, logic [31:0] v);
    enc_t r;
    r = e;
    for (int i = 0; i < 4; i++) r = put8(r, v[8*i +: 8]);
    return r;
  endfunction

  function automatic enc_t put64(enc_t e, logic [63:0] v);
    enc_t r;
    r = e;
    for (int i = 0; i < 8; i++) r = put8(r, v[8*i +: 8]);
    return r;
  endfunction

  function automatic enc_t rex(enc_t e, logic w, logic [3:0] rg, logic [3:0] rm);
    enc_t r;
    r = e;
    if (w || rg[3] || rm[3]) r = put8(r, {4'h4, w, rg[3], 1'b0, rm[3]});
    return r;
  endfunction

  function automatic logic [7:0] modrm_regs(logic [3:0] rg, logic [3:0] rm);
    return {2'b11, rg[2:0], rm[2:0]};
  endfunction

endpackage

// ----- design/xenc_front.sv -----
// Front end: classifies a request by form and builds its whole byte string.
// Depends on xenc_pkg.
`timescale 1ns / 1ps
module xenc_front #(
  parameter int unsigned SAVE_REGS_MAX = 4
) (
  input  xenc_pkg::in_t  req_i,
  input  logic [3:0]     cpu_base_reg_i,
  input  logic [3:0]     count_reg_i,
  output xenc_pkg::enc_t enc_o
);

  xenc_pkg::enc_t e;
  logic [2:0]     ns;
  logic [3:0]     ra, rb, cb;

  assign ra = req_i.reg_a;
  assign rb = req_i.reg_b;
  assign cb = cpu_base_reg_i;
  assign ns = (req_i.saved_count > 3'(SAVE_REGS_MAX)) ? 3'(SAVE_REGS_MAX)
                                                      : req_i.saved_count;

  always_comb begin
    e = '0;
    unique case (xenc_pkg::cmd_e'(req_i.cmd))
      xenc_pkg::CMD_CPU_LD, xenc_pkg::CMD_CPU_ST: begin
        e = xenc_pkg::rex(e, 1'b0, ra, cb);
        e = xenc_pkg::put8(e, (req_i.cmd == xenc_pkg::CMD_CPU_LD) ? 8'h8B : 8'h89);
        e = xenc_pkg::put8(e, {2'b10, ra[2:0], cb[2:0]});
        e = xenc_pkg::put32(e, req_i.disp);
      end
      xenc_pkg::CMD_MOV_RR, xenc_pkg::CMD_ALU_RR: begin
        e = xenc_pkg::rex(e, 1'b0, rb, ra);
        e = xenc_pkg::put8(e, (req_i.cmd == xenc_pkg::CMD_MOV_RR) ? 8'h89
                                                                   : req_i.opcode_byte);
        e = xenc_pkg::put8(e, xenc_pkg::modrm_regs(rb, ra));
      end
      xenc_pkg::CMD_MOV_I32: begin
        e = xenc_pkg::rex(e, 1'b0, 4'd0, ra);
        e = xenc_pkg::put8(e, {5'b10111, ra[2:0]});
        e = xenc_pkg::put32(e, req_i.imm[31:0]);
      end
      xenc_pkg::CMD_MOV_I64: begin
        e = xenc_pkg::rex(e, 1'b1, 4'd0, ra);
        e = xenc_pkg::put8(e, {5'b10111, ra[2:0]});
        e = xenc_pkg::put64(e, req_i.imm);
      end
      xenc_pkg::CMD_ALU_RSP, xenc_pkg::CMD_RSP_LD, xenc_pkg::CMD_RSP_ST: begin
        e = xenc_pkg::rex(e, 1'b0, ra, 4'd0);
        if (req_i.cmd == xenc_pkg::CMD_ALU_RSP) begin
          e = xenc_pkg::put8(e, req_i.opcode_byte | 8'h02);
        end else begin
          e = xenc_pkg::put8(e, (req_i.cmd == xenc_pkg::CMD_RSP_LD) ? 8'h8B : 8'h89);
        end
        e = xenc_pkg::put8(e, {2'b10, ra[2:0], 3'b100});
        e = xenc_pkg::put8(e, 8'h24);
        e = xenc_pkg::put32(e, req_i.disp);
      end
      xenc_pkg::CMD_GRP_F7, xenc_pkg::CMD_SHIFT_CL: begin
        e = xenc_pkg::rex(e, 1'b0, 4'd0, ra);
        e = xenc_pkg::put8(e, (req_i.cmd == xenc_pkg::CMD_GRP_F7) ? 8'hF7 : 8'hD3);
        e = xenc_pkg::put8(e, xenc_pkg::modrm_regs({1'b0, req_i.sub_op}, ra));
      end
      xenc_pkg::CMD_BSWAP: begin
        e = xenc_pkg::rex(e, 1'b0, 4'd0, ra);
        e = xenc_pkg::put8(e, 8'h0F);
        e = xenc_pkg::put8(e, {5'b11001, ra[2:0]});
      end
      xenc_pkg::CMD_ADD_I8, xenc_pkg::CMD_AND_I8: begin
        e = xenc_pkg::rex(e, 1'b0, 4'd0, ra);
        e = xenc_pkg::put8(e, 8'h83);
        e = xenc_pkg::put8(e, xenc_pkg::modrm_regs(
              (req_i.cmd == xenc_pkg::CMD_ADD_I8) ? 4'd0 : 4'd4, ra));
        e = xenc_pkg::put8(e, req_i.imm[7:0]);
      end
      xenc_pkg::CMD_SHIFT_I: begin
        e = xenc_pkg::rex(e, 1'b0, 4'd0, ra);
        e = xenc_pkg::put8(e, 8'hC1);
        e = xenc_pkg::put8(e, xenc_pkg::modrm_regs({1'b0, req_i.sub_op}, ra));
        e = xenc_pkg::put8(e, {3'b000, req_i.imm[4:0]});
      end
      xenc_pkg::CMD_SETCC: begin
        e = xenc_pkg::put8(e, 8'h0F);
        e = xenc_pkg::put8(e, 8'h90 + req_i.opcode_byte);
        e = xenc_pkg::put8(e, 8'hC0);
        e = xenc_pkg::put8(e, 8'h0F);
        e = xenc_pkg::put8(e, 8'hB6);
        e = xenc_pkg::put8(e, 8'hC0);
      end
      xenc_pkg::CMD_MOVSX8, xenc_pkg::CMD_MOVSX16,
      xenc_pkg::CMD_MOVZX8, xenc_pkg::CMD_MOVZX16: begin
        e = xenc_pkg::rex(e, 1'b0, ra, rb);
        e = xenc_pkg::put8(e, 8'h0F);
        e = xenc_pkg::put8(e, (req_i.cmd == xenc_pkg::CMD_MOVSX8)  ? 8'hBE :
                              (req_i.cmd == xenc_pkg::CMD_MOVSX16) ? 8'hBF :
                              (req_i.cmd == xenc_pkg::CMD_MOVZX8)  ? 8'hB6 : 8'hB7);
        e = xenc_pkg::put8(e, xenc_pkg::modrm_regs(ra, rb));
      end
      xenc_pkg::CMD_JCC: begin
        e = xenc_pkg::put8(e, 8'h0F);
        e = xenc_pkg::put8(e, req_i.opcode_byte);
        e = xenc_pkg::put32(e, 32'd0);
      end
      xenc_pkg::CMD_JMP: begin
        e = xenc_pkg::put8(e, 8'hE9);
        e = xenc_pkg::put32(e, 32'd0);
      end
      xenc_pkg::CMD_CALL_RAX: begin
        e = xenc_pkg::put8(e, 8'hFF);
        e = xenc_pkg::put8(e, 8'hD0);
      end
      xenc_pkg::CMD_PROLOGUE: begin
        e = xenc_pkg::put8(e, 8'h53);
        e = xenc_pkg::put8(e, 8'h55);
        e = xenc_pkg::put8(e, 8'h48);
        e = xenc_pkg::put8(e, 8'h83);
        e = xenc_pkg::put8(e, 8'hEC);
        e = xenc_pkg::put8(e, 8'h08);
        e = xenc_pkg::put8(e, 8'h48);
        e = xenc_pkg::put8(e, 8'h89);
        e = xenc_pkg::put8(e, 8'hFB);
        e = xenc_pkg::put8(e, 8'h31);
        e = xenc_pkg::put8(e, 8'hED);
        // r12 upwards, each needs REX.B
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < ns) begin
            e = xenc_pkg::put8(e, 8'h41);
            e = xenc_pkg::put8(e, 8'h54 + 8'(i));
          end
        end
      end
      xenc_pkg::CMD_EPILOGUE: begin
        // pops in reverse order of the pushes
        for (int k = 0; k < 4; k++) begin
          if (3'(k) < ns) begin
            e = xenc_pkg::put8(e, 8'h41);
            e = xenc_pkg::put8(e, 8'h5C + 8'(ns) - 8'd1 - 8'(k));
          end
        end
        e = xenc_pkg::put8(e, 8'h89);
        e = xenc_pkg::put8(e, 8'hE8);
        e = xenc_pkg::put8(e, 8'h48);
        e = xenc_pkg::put8(e, 8'h83);
        e = xenc_pkg::put8(e, 8'hC4);
        e = xenc_pkg::put8(e, 8'h08);
        e = xenc_pkg::put8(e, 8'h5D);
        e = xenc_pkg::put8(e, 8'h5B);
        e = xenc_pkg::put8(e, 8'hC3);
      end
      xenc_pkg::CMD_MOVD_TOX, xenc_pkg::CMD_MOVD_FROMX: begin
        e = xenc_pkg::put8(e, 8'h66);
        e = xenc_pkg::rex(e, 1'b0, rb, ra);
        e = xenc_pkg::put8(e, 8'h0F);
        e = xenc_pkg::put8(e, (req_i.cmd == xenc_pkg::CMD_MOVD_TOX) ? 8'h6E : 8'h7E);
        e = xenc_pkg::put8(e, xenc_pkg::modrm_regs(rb, ra));
      end
      xenc_pkg::CMD_SSE_F3, xenc_pkg::CMD_CVT_SS2SI: begin
        e = xenc_pkg::put8(e, 8'hF3);
        e = xenc_pkg::rex(e, 1'b0, ra, rb);
        e = xenc_pkg::put8(e, 8'h0F);
        if (req_i.cmd == xenc_pkg::CMD_SSE_F3) begin
          e = xenc_pkg::put8(e, req_i.opcode_byte);
        end else begin
          e = xenc_pkg::put8(e, req_i.truncate ? 8'h2C : 8'h2D);
        end
        e = xenc_pkg::put8(e, xenc_pkg::modrm_regs(ra, rb));
      end
      xenc_pkg::CMD_UCOMISS: begin
        e = xenc_pkg::rex(e, 1'b0, ra, rb);
        e = xenc_pkg::put8(e, 8'h0F);
        e = xenc_pkg::put8(e, 8'h2E);
        e = xenc_pkg::put8(e, xenc_pkg::modrm_regs(ra, rb));
      end
      xenc_pkg::CMD_CVT_SI2SS: begin
        e = xenc_pkg::put8(e, 8'hF3);
        e = xenc_pkg::rex(e, 1'b0, rb, ra);
        e = xenc_pkg::put8(e, 8'h0F);
        e = xenc_pkg::put8(e, 8'h2A);
        e = xenc_pkg::put8(e, xenc_pkg::modrm_regs(rb, ra));
      end
      xenc_pkg::CMD_STMXCSR, xenc_pkg::CMD_LDMXCSR: begin
        e = xenc_pkg::put8(e, 8'h0F);
        e = xenc_pkg::put8(e, 8'hAE);
        e = xenc_pkg::put8(e, (req_i.cmd == xenc_pkg::CMD_STMXCSR) ? 8'h9C : 8'h94);
        e = xenc_pkg::put8(e, 8'h24);
        e = xenc_pkg::put32(e, req_i.disp);
      end
      xenc_pkg::CMD_MOVZX_IDX: begin
        e = xenc_pkg::rex(e, 1'b0, ra, rb);
        e = xenc_pkg::put8(e, 8'h0F);
        e = xenc_pkg::put8(e, 8'hB6);
        e = xenc_pkg::put8(e, {2'b00, ra[2:0], 3'b100});
        e = xenc_pkg::put8(e, {2'b00, req_i.reg_c[2:0], rb[2:0]});
      end
      xenc_pkg::CMD_COUNT: begin
        e = xenc_pkg::rex(e, 1'b0, 4'd0, count_reg_i);
        e = xenc_pkg::put8(e, 8'h83);
        e = xenc_pkg::put8(e, xenc_pkg::modrm_regs(4'd0, count_reg_i));
        e = xenc_pkg::put8(e, 8'h01);
      end
      default: e = '0; // unused selector: empty encoding
    endcase
  end

  assign enc_o = e;

endmodule

// ----- design/xenc_queue.sv -----
// Two-entry queue of built encodings between front and back end.
// Depends on xenc_pkg.
`timescale 1ns / 1ps
module xenc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xenc_pkg::enc_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output xenc_pkg::enc_t pop_data_o
);

  xenc_pkg::enc_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- design/xenc_back.sv -----
// Back end: streams one queued encoding out a byte at a time, flags the last byte.
// Depends on xenc_pkg.
`timescale 1ns / 1ps
module xenc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  xenc_pkg::enc_t q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output xenc_pkg::out_t out_data_o
);

  xenc_pkg::enc_t                 cur_q;
  logic [xenc_pkg::LenW-1:0]      idx_q;
  logic                           busy_q;
  logic                           is_last;

  assign is_last = (idx_q == cur_q.len - xenc_pkg::LenW'(1));
  // take the next encoding when idle or as the last byte leaves
  assign q_pop_o = !q_empty_i && (!busy_q || (out_ready_i && is_last));

  assign out_valid_o         = busy_q;
  assign out_data_o.out_byte = cur_q.bytes[idx_q];
  assign out_data_o.last     = is_last;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      if (is_last) busy_q <= 1'b0;
      else         idx_q  <= idx_q + xenc_pkg::LenW'(1);
    end
  end

endmodule

// ----- design/x86_64_instruction_byte_encoder.sv -----
// Top level of the x86-64 instruction byte encoder: front end, queue, back end, registers.
// Depends on xenc_pkg, xenc_front, xenc_queue, xenc_back.
//
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i/in_ready_o  | xenc_pkg::in_t
//  out     | source    | out_valid_o/out_ready_i| xenc_pkg::out_t
//  cfg     | sink      | psel/penable/pready    | pwdata/prdata
//
// A request is encoded in the cycle it is accepted and queued (two deep);
// the back end then sends one byte per cycle while out_ready_i is high, 2 to 19 bytes
// a request. Requests with an unused selector take no bytes.
// in_ready_o drops only while the queue is full; a stalled output holds.
// Reset empties the queue, idles the back end and sets the registers to 3 and 5.
`timescale 1ns / 1ps
module x86_64_instruction_byte_encoder #(
  parameter int unsigned SAVE_REGS_MAX = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  xenc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output xenc_pkg::out_t out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [3:0]     cpu_base_reg_q, count_reg_q;
  xenc_pkg::enc_t enc, q_data;
  logic           q_full, q_empty, q_pop, push;

  assign pready = 1'b1;
  assign prdata = {28'd0, (xenc_pkg::reg_idx_e'(paddr[2]) == xenc_pkg::REG_COUNT)
                          ? count_reg_q : cpu_base_reg_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_base_reg_q <= 4'd3;
      count_reg_q    <= 4'd5;
    end else if (psel && penable && pwrite) begin
      if (xenc_pkg::reg_idx_e'(paddr[2]) == xenc_pkg::REG_CPU_BASE) begin
        cpu_base_reg_q <= pwdata[3:0];
      end else begin
        count_reg_q <= pwdata[3:0];
      end
    end
  end

  xenc_front #(.SAVE_REGS_MAX(SAVE_REGS_MAX)) u_front (
    .req_i          (in_data_i),
    .cpu_base_reg_i (cpu_base_reg_q),
    .count_reg_i    (count_reg_q),
    .enc_o          (enc)
  );

  assign in_ready_o = !q_full;
  // empty encodings are dropped here
  assign push = in_valid_i && !q_full && (enc.len != '0);

  xenc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (enc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_data)
  );

  xenc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- design/xenc_checker.sv -----
// Port-level checker for the x86-64 instruction byte encoder, bound to the top level.
// Depends on xenc_pkg.
`timescale 1ns / 1ps
module xenc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input xenc_pkg::out_t out_data_o,
  input logic           psel,
  input logic           penable,
  input logic           pwrite,
  input logic [2:0]     paddr,
  input logic [31:0]    pwdata,
  input logic [31:0]    prdata,
  input logic           pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output byte changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_rd_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=>
      (paddr[2] != $past(paddr[2])) || (prdata[3:0] == $past(pwdata[3:0])))
    else $error("register read does not return written value");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:4] == 28'd0)
    else $error("unused register bits set");

endmodule

bind x86_64_instruction_byte_encoder xenc_checker u_xenc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);

// ----- sim/xenc_checker.sv -----
// Scoreboard for the x86-64 instruction byte encoder: predicts each request's bytes.
// Depends on xenc_pkg; watches the in and out channels and the register port.
`timescale 1ns / 1ps
module xenc_scoreboard (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  xenc_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  xenc_pkg::out_t out_data_i,
  input  logic           psel_i,
  input  logic           penable_i,
  input  logic           pwrite_i,
  input  logic [2:0]     paddr_i,
  input  logic [31:0]    pwdata_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             bytes_seen_o
);

  logic [3:0]     cpu_base_q;
  logic [3:0]     count_reg_q;
  xenc_pkg::out_t byte_queue[$];
  logic [7:0]     code[$];

  assign pending_o = byte_queue.size();

  function automatic void emit(logic [7:0] b);
    code.push_back(b);
  endfunction

  function automatic void emit32(logic [31:0] v);
    for (int i = 0; i < 4; i++) emit(v[8*i +: 8]);
  endfunction

  function automatic void put_rex(logic w, logic [3:0] rg, logic [3:0] rm);
    if (w || rg[3] || rm[3]) emit({4'h4, w, rg[3], 1'b0, rm[3]});
  endfunction

  function automatic void emit_rr(logic [2:0] rg, logic [2:0] rm);
    emit({2'b11, rg, rm});
  endfunction

  function automatic void emit_rsp(logic [7:0] op, logic [3:0] r, logic [31:0] d);
    put_rex(1'b0, r, 4'd0);
    emit(op);
    emit({2'b10, r[2:0], 3'b100});
    emit(8'h24);
    emit32(d);
  endfunction

  function automatic void emit_sse(logic [7:0] pfx, logic [7:0] op2,
                                   logic [3:0] rg, logic [3:0] rm);
    if (pfx != 8'h00) emit(pfx);
    put_rex(1'b0, rg, rm);
    emit(8'h0F);
    emit(op2);
    emit_rr(rg[2:0], rm[2:0]);
  endfunction

  // Builds the expected machine code for one request into code
  function automatic void encode_request(xenc_pkg::in_t q);
    int ns;
    logic [3:0] rr;
    code.delete();
    ns = (q.saved_count > 3'd4) ? 4 : int'(q.saved_count);
    case (q.cmd)
      xenc_pkg::CMD_CPU_LD, xenc_pkg::CMD_CPU_ST: begin
        put_rex(1'b0, q.reg_a, cpu_base_q);
        emit(q.cmd == xenc_pkg::CMD_CPU_LD ? 8'h8B : 8'h89);
        emit({2'b10, q.reg_a[2:0], cpu_base_q[2:0]});
        emit32(q.disp);
      end
      xenc_pkg::CMD_MOV_RR, xenc_pkg::CMD_ALU_RR: begin
        put_rex(1'b0, q.reg_b, q.reg_a);
        emit(q.cmd == xenc_pkg::CMD_MOV_RR ? 8'h89 : q.opcode_byte);
        emit_rr(q.reg_b[2:0], q.reg_a[2:0]);
      end
      xenc_pkg::CMD_MOV_I32: begin
        put_rex(1'b0, 4'd0, q.reg_a);
        emit(8'hB8 + q.reg_a[2:0]);
        emit32(q.imm[31:0]);
      end
      xenc_pkg::CMD_MOV_I64: begin
        put_rex(1'b1, 4'd0, q.reg_a);
        emit(8'hB8 + q.reg_a[2:0]);
        emit32(q.imm[31:0]);
        emit32(q.imm[63:32]);
      end
      xenc_pkg::CMD_ALU_RSP: emit_rsp(q.opcode_byte | 8'h02, q.reg_a, q.disp);
      xenc_pkg::CMD_RSP_LD:  emit_rsp(8'h8B, q.reg_a, q.disp);
      xenc_pkg::CMD_RSP_ST:  emit_rsp(8'h89, q.reg_a, q.disp);
      xenc_pkg::CMD_GRP_F7, xenc_pkg::CMD_SHIFT_CL, xenc_pkg::CMD_SHIFT_I,
      xenc_pkg::CMD_ADD_I8, xenc_pkg::CMD_AND_I8, xenc_pkg::CMD_COUNT: begin
        rr = (q.cmd == xenc_pkg::CMD_COUNT) ? count_reg_q : q.reg_a;
        put_rex(1'b0, 4'd0, rr);
        case (q.cmd)
          xenc_pkg::CMD_GRP_F7:   begin emit(8'hF7); emit_rr(q.sub_op, rr[2:0]); end
          xenc_pkg::CMD_SHIFT_CL: begin emit(8'hD3); emit_rr(q.sub_op, rr[2:0]); end
          xenc_pkg::CMD_SHIFT_I: begin
            emit(8'hC1); emit_rr(q.sub_op, rr[2:0]); emit({3'b000, q.imm[4:0]});
          end
          xenc_pkg::CMD_ADD_I8: begin
            emit(8'h83); emit_rr(3'd0, rr[2:0]); emit(q.imm[7:0]);
          end
          xenc_pkg::CMD_AND_I8: begin
            emit(8'h83); emit_rr(3'd4, rr[2:0]); emit(q.imm[7:0]);
          end
          default: begin emit(8'h83); emit_rr(3'd0, rr[2:0]); emit(8'h01); end
        endcase
      end
      xenc_pkg::CMD_BSWAP: begin
        put_rex(1'b0, 4'd0, q.reg_a);
        emit(8'h0F);
        emit(8'hC8 + q.reg_a[2:0]);
      end
      xenc_pkg::CMD_SETCC: begin
        emit(8'h0F); emit(8'h90 + q.opcode_byte); emit(8'hC0);
        emit(8'h0F); emit(8'hB6); emit(8'hC0);
      end
      xenc_pkg::CMD_MOVSX8, xenc_pkg::CMD_MOVSX16,
      xenc_pkg::CMD_MOVZX8, xenc_pkg::CMD_MOVZX16: begin
        put_rex(1'b0, q.reg_a, q.reg_b);
        emit(8'h0F);
        case (q.cmd)
          xenc_pkg::CMD_MOVSX8:  emit(8'hBE);
          xenc_pkg::CMD_MOVSX16: emit(8'hBF);
          xenc_pkg::CMD_MOVZX8:  emit(8'hB6);
          default:               emit(8'hB7);
        endcase
        emit_rr(q.reg_a[2:0], q.reg_b[2:0]);
      end
      xenc_pkg::CMD_JCC: begin emit(8'h0F); emit(q.opcode_byte); emit32(32'd0); end
      xenc_pkg::CMD_JMP: begin emit(8'hE9); emit32(32'd0); end
      xenc_pkg::CMD_CALL_RAX: begin emit(8'hFF); emit(8'hD0); end
      xenc_pkg::CMD_PROLOGUE: begin
        emit(8'h53); emit(8'h55);
        emit(8'h48); emit(8'h83); emit(8'hEC); emit(8'h08);
        emit(8'h48); emit(8'h89); emit(8'hFB);
        emit(8'h31); emit(8'hED);
        for (int i = 0; i < ns; i++) begin emit(8'h41); emit(8'h54 + i); end
      end
      xenc_pkg::CMD_EPILOGUE: begin
        for (int i = ns - 1; i >= 0; i--) begin emit(8'h41); emit(8'h5C + i); end
        emit(8'h89); emit(8'hE8);
        emit(8'h48); emit(8'h83); emit(8'hC4); emit(8'h08);
        emit(8'h5D); emit(8'h5B); emit(8'hC3);
      end
      xenc_pkg::CMD_MOVD_TOX:   emit_sse(8'h66, 8'h6E, q.reg_b, q.reg_a);
      xenc_pkg::CMD_MOVD_FROMX: emit_sse(8'h66, 8'h7E, q.reg_b, q.reg_a);
      xenc_pkg::CMD_SSE_F3:     emit_sse(8'hF3, q.opcode_byte, q.reg_a, q.reg_b);
      xenc_pkg::CMD_UCOMISS:    emit_sse(8'h00, 8'h2E, q.reg_a, q.reg_b);
      xenc_pkg::CMD_CVT_SS2SI:
        emit_sse(8'hF3, q.truncate ? 8'h2C : 8'h2D, q.reg_a, q.reg_b);
      xenc_pkg::CMD_CVT_SI2SS:  emit_sse(8'hF3, 8'h2A, q.reg_b, q.reg_a);
      xenc_pkg::CMD_STMXCSR, xenc_pkg::CMD_LDMXCSR: begin
        emit(8'h0F); emit(8'hAE);
        emit(q.cmd == xenc_pkg::CMD_STMXCSR ? 8'h9C : 8'h94);
        emit(8'h24);
        emit32(q.disp);
      end
      xenc_pkg::CMD_MOVZX_IDX: begin
        put_rex(1'b0, q.reg_a, q.reg_b);
        emit(8'h0F); emit(8'hB6);
        emit({2'b00, q.reg_a[2:0], 3'b100});
        emit({2'b00, q.reg_c[2:0], q.reg_b[2:0]});
      end
      default: ;
    endcase
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    xenc_pkg::out_t want;
    if (!rst_ni) begin
      cpu_base_q    <= 4'd3;
      count_reg_q   <= 4'd5;
      fail_count_o  <= 0;
      bytes_seen_o  <= 0;
      byte_queue.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i) begin
        if (paddr_i[2] == xenc_pkg::REG_COUNT) count_reg_q <= pwdata_i[3:0];
        else cpu_base_q <= pwdata_i[3:0];
      end
      if (in_valid_i && in_ready_i) begin
        encode_request(in_data_i);
        foreach (code[i]) byte_queue.push_back('{code[i], i == code.size() - 1});
      end
      if (out_valid_i && out_ready_i) begin
        bytes_seen_o <= bytes_seen_o + 1;
        if (byte_queue.size() == 0) begin
          $error("unexpected byte %h", out_data_i.out_byte);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = byte_queue.pop_front();
          if (want.out_byte !== out_data_i.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_data_i.out_byte);
            fail_count_o <= fail_count_o + 1;
          end else if (want.last !== out_data_i.last) begin
            $error("last: expected %b, got %b", want.last, out_data_i.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- sim/tb_x86_64_instruction_byte_encoder.sv -----
// Testbench top for the x86-64 instruction byte encoder: stimulus, registers, verdict.
// Depends on xenc_pkg, x86_64_instruction_byte_encoder and xenc_scoreboard.
`timescale 1ns / 1ps
module tb_x86_64_instruction_byte_encoder;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  xenc_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  xenc_pkg::out_t out_data_o;
  logic           psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;
  int             fail_count, pending, bytes_seen;
  int             requests_sent = 0;
  bit             hold_off = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  x86_64_instruction_byte_encoder u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  xenc_scoreboard u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_count_o(fail_count), .pending_o(pending),
    .bytes_seen_o(bytes_seen)
  );

  // Receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (hold_off) out_ready_i <= 1'b0;
      else if (phase % 200 < 60) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_reg(xenc_pkg::reg_idx_e idx, logic [3:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= {28'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk_i);
    repeat (25) @(negedge clk_i);
  endtask

  // Offers one request and waits for its acceptance; valid stays high between requests
  task automatic send_request(xenc_pkg::in_t q);
    in_valid_i <= 1'b1;
    in_data_i  <= q;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
    @(negedge clk_i);
  endtask

  function automatic xenc_pkg::in_t random_request(bit any_cmd);
    xenc_pkg::in_t q;
    q = xenc_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    q.cmd = any_cmd ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 34));
    q.saved_count = 3'($urandom_range(0, 7));
    return q;
  endfunction

  task automatic random_burst(int n);
    int left;
    left = n;
    while (left > 0) begin
      for (int b = $urandom_range(1, 8); b > 0 && left > 0; b--) begin
        send_request(random_request($urandom_range(0, 9) == 0));
        left--;
      end
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    xenc_pkg::in_t q;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: forms 0 to 24 with extreme fields, clamped saves, unused selectors
    for (int c = 0; c <= 35; c++) begin
      q = '0;
      q.cmd = 6'(c);
      if (c % 2 == 1) begin
        q.reg_a = 4'hF; q.reg_b = 4'hF; q.reg_c = 4'hF; q.opcode_byte = 8'hFF;
        q.sub_op = 3'd7; q.disp = '1; q.imm = '1; q.truncate = 1'b1; q.saved_count = 3'd7;
      end else begin
        q.reg_b = 4'h8; q.opcode_byte = 8'h70; q.saved_count = 3'd4;
        q.disp = 32'h12345678; q.imm = 64'h0123456789ABCDEF;
      end
      if (c < 25 || c == 35) send_request(q);
    end
    q.cmd = 6'd63;
    send_request(q);
    in_valid_i <= 1'b0;
    drain();

    // Registers: extremes, including a base with low bits of four
    write_reg(xenc_pkg::REG_CPU_BASE, 4'd0); write_reg(xenc_pkg::REG_COUNT, 4'd15);
    for (int c = 25; c <= 34; c++) begin
      q = random_request(1'b0);
      q.cmd = 6'(c);
      send_request(q);
    end
    q.cmd = xenc_pkg::CMD_CPU_LD;
    send_request(q);
    in_valid_i <= 1'b0;
    drain();
    write_reg(xenc_pkg::REG_CPU_BASE, 4'd12); write_reg(xenc_pkg::REG_COUNT, 4'd0);
    random_burst(20);

    // Long receiver hold-off while requests keep coming
    hold_off = 1'b1;
    fork
      random_burst(10);
      begin repeat (150) @(negedge clk_i); hold_off = 1'b0; end
    join
    drain();

    write_reg(xenc_pkg::REG_CPU_BASE, 4'd15); write_reg(xenc_pkg::REG_COUNT, 4'd8);
    random_burst(20);
    drain();
    write_reg(xenc_pkg::REG_CPU_BASE, 4'($urandom));
    write_reg(xenc_pkg::REG_COUNT, 4'($urandom));
    random_burst(20);
    drain();

    $display("Run covered %0d requests over all forms and %0d bytes,",
             requests_sent, bytes_seen);
    $display("with register extremes, saves clamping, unused selectors and back-pressure.");
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
